FILE: rtl/core/stiab_pkg.sv
// ----------------------------------------------------------------------------
// stiab_pkg: shared types and constants of the string to integer parser
// Register indexes, reset values, character codes and the token that the
// front stage hands to the back stage.
// ----------------------------------------------------------------------------
package stiab_pkg;

  localparam int CHAR_W     = 8;
  localparam int BASE_W     = 5;
  localparam int SYM_IDX_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  // Register reset values: base ten over "0123456789"
  localparam logic [BASE_W-1:0]     BASE_SIZE_RST    = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'd3978425819141910832;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'd14648;

  localparam logic [BASE_W-1:0] MIN_BASE = 5'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
  localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_CTRL_MAX = 8'd31;

  // One classified character
  typedef struct packed {
    logic                 is_ws;
    logic                 is_plus;
    logic                 is_minus;
    logic                 is_digit;
    logic [SYM_IDX_W-1:0] digit_idx;
    logic [BASE_W-1:0]    base;
    logic                 last;
    logic                 bad;
  } tok_t;

endpackage

FILE: rtl/core/stiab_front.sv
// ----------------------------------------------------------------------------
// stiab_front: configuration registers and character classifier
// Holds the alphabet registers, matches each accepted character against all
// symbols in parallel and judges the alphabet on the last character.
// ----------------------------------------------------------------------------
module stiab_front #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stiab_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [stiab_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                push_i,
  input  logic                                full_i,
  input  logic [stiab_pkg::CHAR_W-1:0]        character_i,
  input  logic                                last_i,
  output logic                                tok_valid_o,
  output stiab_pkg::tok_t                     tok_o
);
  import stiab_pkg::*;

  logic [BASE_W-1:0]     base_size_q;
  logic [CFG_DATA_W-1:0] symbols_low_q;
  logic [CFG_DATA_W-1:0] symbols_high_q;

  logic [2*CFG_DATA_W-1:0] sym_flat;
  logic [CHAR_W-1:0]       sym [MAX_SYMBOLS];
  logic                    hit;
  logic [SYM_IDX_W-1:0]    idx;
  logic                    bad;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_size_q    <= BASE_SIZE_RST;
      symbols_low_q  <= SYMBOLS_LOW_RST;
      symbols_high_q <= SYMBOLS_HIGH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BASE_SIZE:    base_size_q    <= cfg_data_i[BASE_W-1:0];
        CFG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data_i;
        CFG_SYMBOLS_HIGH: symbols_high_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign sym_flat = {symbols_high_q, symbols_low_q};

  always_comb begin
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      sym[i] = sym_flat[CHAR_W*i +: CHAR_W];
    end
  end

  // Lowest matching index wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if ((BASE_W'(i) < base_size_q) && (sym[i] == character_i)) begin
        hit = 1'b1;
        idx = SYM_IDX_W'(i);
      end
    end
  end

  always_comb begin
    bad = (base_size_q < MIN_BASE) || (base_size_q > BASE_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (BASE_W'(i) < base_size_q) begin
        if ((sym[i] <= CH_CTRL_MAX) || (sym[i] == CH_PLUS) ||
            (sym[i] == CH_MINUS) || (sym[i] == CH_SPACE)) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if ((BASE_W'(j) < base_size_q) && (sym[j] == sym[i])) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign tok_valid_o     = push_i && !full_i;
  assign tok_o.is_ws     = (character_i == CH_SPACE) ||
                           ((character_i >= CH_TAB) && (character_i <= CH_CR));
  assign tok_o.is_plus   = (character_i == CH_PLUS);
  assign tok_o.is_minus  = (character_i == CH_MINUS);
  assign tok_o.is_digit  = hit;
  assign tok_o.digit_idx = idx;
  assign tok_o.base      = base_size_q;
  assign tok_o.last      = last_i;
  assign tok_o.bad       = bad;

endmodule

FILE: rtl/core/stiab_queue.sv
// ----------------------------------------------------------------------------
// stiab_queue: two-entry token queue
// Decouples the classifier from the accumulator so each side stalls alone.
// ----------------------------------------------------------------------------
module stiab_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  stiab_pkg::tok_t  wr_tok_i,
  output logic             full_o,
  output logic             rd_valid_o,
  output stiab_pkg::tok_t  rd_tok_o,
  input  logic             rd_ready_i
);
  import stiab_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             wr_en;
  logic             rd_en;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_tok_o   = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && !full_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(DEPTH))
    else $error("token queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("token queue lost a write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && !wr_en) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("token queue lost a read");

endmodule

FILE: rtl/core/stiab_back.sv
// ----------------------------------------------------------------------------
// stiab_back: parse sequencer and result register
// Walks white space, sign, digit phases one token a cycle (a last token waits
// for a held result); multiply-accumulates; last token loads result register.
// ----------------------------------------------------------------------------
module stiab_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tok_valid_i,
  input  stiab_pkg::tok_t              tok_i,
  output logic                         tok_ready_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic signed [VALUE_BITS-1:0] value_o,
  output logic                         alphabet_bad_o
);
  import stiab_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_e;

  phase_e                phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [VALUE_BITS-1:0] mac;
  logic [VALUE_BITS-1:0] res;
  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic                  out_bad_q;
  logic                  out_take;
  logic                  tok_take;

  assign out_take    = pop_i && out_valid_q;
  assign tok_ready_o = !tok_i.last || !out_valid_q || pop_i;
  assign tok_take    = tok_valid_i && tok_ready_o;

  assign mac = VALUE_BITS'(acc_q * VALUE_BITS'(tok_i.base)) + VALUE_BITS'(tok_i.digit_idx);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (phase_d == PH_SKIP && !tok_i.is_ws) begin
      phase_d = PH_SIGN;
    end
    if (phase_d == PH_SIGN) begin
      if (tok_i.is_minus) begin
        neg_d = !neg_d;
      end else if (!tok_i.is_plus) begin
        phase_d = PH_DIGIT;
      end
    end
    if (phase_d == PH_DIGIT) begin
      if (tok_i.is_digit) begin
        acc_d = mac;
      end else begin
        phase_d = PH_DONE;
      end
    end
    res = neg_d ? (VALUE_BITS'(0) - acc_d) : acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_bad_q   <= 1'b0;
    end else begin
      if (tok_take && tok_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (tok_take) begin
        if (tok_i.last) begin
          // end of text: hand off the result and start over
          phase_q     <= PH_SKIP;
          neg_q       <= 1'b0;
          acc_q       <= '0;
          out_value_q <= tok_i.bad ? '0 : res;
          out_bad_q   <= tok_i.bad;
        end else begin
          phase_q <= phase_d;
          neg_q   <= neg_d;
          acc_q   <= acc_d;
        end
      end
    end
  end

  assign empty_o        = !out_valid_q;
  assign value_o        = out_value_q;
  assign alphabet_bad_o = out_bad_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_take && tok_i.last) |=> (out_valid_q && phase_q == PH_SKIP && !neg_q && acc_q == '0))
    else $error("last token did not close the text");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_value_q == '0))
    else $error("bad alphabet result carries a value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i && tok_valid_i && tok_i.last) |-> !tok_take)
    else $error("result overwritten while waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE && !(tok_take && tok_i.last)) |=>
      (phase_q == PH_DONE && acc_q == $past(acc_q)))
    else $error("parse resumed after it ended");

endmodule

FILE: rtl/core/string_to_integer_any_base.sv
// ----------------------------------------------------------------------------
// string_to_integer_any_base: text to signed integer over a digit alphabet
// Parses characters against a configurable alphabet of up to MAX_SYMBOLS
// symbols and returns the signed, wrapped value at the end of each text.
// ----------------------------------------------------------------------------
// Usage:
//   Write characters through push/full; an item transfers when push is high
//   and full is low. Mark the final character of a text with last_i.
//   Each text yields one result on the output queue: the oldest result sits
//   on value_o/alphabet_bad_o while empty is low and transfers on pop.
//   The config channel (cfg_valid_i/cfg_ready_o) is always ready; write
//   base_size, symbols_low and symbols_high at indexes 0, 1, 2 while idle.
// Timing:
//   One character per cycle while full stays low. A result becomes visible
//   once its last character has transferred: the token is written into the
//   token queue, and when the accumulator takes it, it loads the result
//   register. The accumulator does one multiply-accumulate per character.
// Stall and reset:
//   While a result waits, characters keep flowing until the next last
//   character reaches the accumulator; the two-entry token queue then fills
//   and raises full. Reset restores base ten over "0123456789", empties
//   both queues and starts the parse in the white space phase.
// ----------------------------------------------------------------------------
module string_to_integer_any_base #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [stiab_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stiab_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic [stiab_pkg::CHAR_W-1:0]     character_i,
  input  logic                             last_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [VALUE_BITS-1:0]     value_o,
  output logic                             alphabet_bad_o
);
  import stiab_pkg::*;

  logic wr_valid;
  tok_t wr_tok;
  logic rd_valid;
  tok_t rd_tok;
  logic rd_ready;

  stiab_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_i      (full),
    .character_i (character_i),
    .last_i      (last_i),
    .tok_valid_o (wr_valid),
    .tok_o       (wr_tok)
  );

  stiab_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_tok_i   (wr_tok),
    .full_o     (full),
    .rd_valid_o (rd_valid),
    .rd_tok_o   (rd_tok),
    .rd_ready_i (rd_ready)
  );

  stiab_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_valid_i    (rd_valid),
    .tok_i          (rd_tok),
    .tok_ready_o    (rd_ready),
    .pop_i          (pop),
    .empty_o        (empty),
    .value_o        (value_o),
    .alphabet_bad_o (alphabet_bad_o)
  );

endmodule
